// ===== rtl/gmdpf_pkg.sv =====
// ----------------------------------------------------------------------------
// gmdpf_pkg
// Shared widths, layout constants and defaults for the greedy minimum-distance
// point filter.
// ----------------------------------------------------------------------------
package gmdpf_pkg;

    localparam int COORD_W       = 17;
    localparam int COORD_FIELDS  = 9;
    localparam int SQ_W          = 2 * COORD_W;
    localparam int THRESH_W      = 36;
    localparam int SIZE_W        = 11;

    localparam int DIMENSIONS_DEF = 9;
    localparam int MAX_POINTS_DEF = 1024;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 36'd1183800361;

    // Slave tdata: start_new, then coord_0 .. coord_8, padded to whole bytes.
    localparam int S_TDATA_RAW = 1 + COORD_FIELDS * COORD_W;
    localparam int S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
    localparam int COORD_LSB   = 1;

    // Master tdata: accepted, store_full, code_size, padded to whole bytes.
    localparam int M_TDATA_RAW = 2 + SIZE_W;
    localparam int M_TDATA_W   = ((M_TDATA_RAW + 7) / 8) * 8;

endpackage

// ===== rtl/greedy_min_distance_point_filter.sv =====
// ----------------------------------------------------------------------------
// greedy_min_distance_point_filter
// Builds a code of points with a guaranteed minimum squared distance.
// ----------------------------------------------------------------------------
// Each offered point is compared with every stored point and appended only if
// its squared Euclidean distance (unsigned Q38.0) to all of them is at least
// min_dist_sq and the store still has room; setting start_new empties the
// store first. Stored points live in one synchronous memory, one point per
// row, and the scan reads one row per cycle through its single read port.
// The scan stops early once a stored point is found too close. One point is
// worked on at a time; the result sits in an output register so the next
// point can be taken while it waits. The threshold may be written whenever
// the block is idle.
module greedy_min_distance_point_filter
#(
    parameter int DIMENSIONS = gmdpf_pkg::DIMENSIONS_DEF,
    parameter int MAX_POINTS = gmdpf_pkg::MAX_POINTS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Fields from bit 0 up: start_new, coord_0 .. coord_8 (17 bits each), zero pad.
    input  logic [gmdpf_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0 up: accepted, store_full, code_size (11 bits), zero pad.
    output logic [gmdpf_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [gmdpf_pkg::THRESH_W-1:0]      cfg_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready
);
    import gmdpf_pkg::*;

    localparam int ROW_W   = DIMENSIONS * COORD_W;
    localparam int CW      = $clog2(MAX_POINTS + 1);
    localparam int AW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SUM_W   = SQ_W + $clog2(DIMENSIONS);
    localparam int CMP_W   = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;
    localparam int HALF    = DIMENSIONS / 2;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          rd_idx_reg, rd_idx_next;
    logic                   fail_reg, fail_next;
    logic                   v1_reg, v1_next;
    logic                   v2_reg, v2_next;
    logic                   v3_reg, v3_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   accepted_reg, accepted_next;
    logic                   full_reg, full_next;
    logic [SIZE_W-1:0]      size_reg, size_next;
    logic [THRESH_W-1:0]    thresh_reg, thresh_next;

    logic [ROW_W-1:0]       cand_in;
    logic [ROW_W-1:0]       cand_reg;
    logic [ROW_W-1:0]       rdata_reg;
    logic [SQ_W-1:0]        sq_reg [DIMENSIONS];
    logic [SUM_W-1:0]       lo_reg, hi_reg;
    logic [SUM_W-1:0]       lo_sum, hi_sum, total;
    logic                   too_close;

    logic [ROW_W-1:0]       mem [MAX_POINTS];
    logic                   mem_we;
    logic                   issue;
    logic                   in_xfer;
    logic                   room;
    logic [CW+SIZE_W-1:0]   size_wide;

    // Offered point as one memory row; dimensions beyond the input fields are zero.
    for (genvar d = 0; d < DIMENSIONS; d++) begin : g_cand
        if (d < COORD_FIELDS) begin : g_field
            assign cand_in[d*COORD_W +: COORD_W] = s_tdata[COORD_LSB + d*COORD_W +: COORD_W];
        end
        else begin : g_zero
            assign cand_in[d*COORD_W +: COORD_W] = '0;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(M_TDATA_W-M_TDATA_RAW){1'b0}}, size_reg, full_reg, accepted_reg};
    assign in_xfer   = s_tvalid && s_tready;
    assign room      = (count_reg < CW'(MAX_POINTS));
    assign issue     = (state_reg == ST_SCAN) && !fail_reg && (rd_idx_reg != count_reg);

    // Final add of the two partial sums and the threshold test.
    always_comb
    begin
        total     = lo_reg + hi_reg;
        too_close = (CMP_W'(total) < CMP_W'(thresh_reg));
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        fail_next      = fail_reg || (v3_reg && too_close);
        v1_next        = issue;
        v2_next        = v1_reg;
        v3_next        = v2_reg;
        out_valid_next = out_valid_reg && !m_tready;
        accepted_next  = accepted_reg;
        full_next      = full_reg;
        size_next      = size_reg;
        thresh_next    = cfg_valid ? cfg_data : thresh_reg;
        mem_we         = 1'b0;
        size_wide      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    rd_idx_next = '0;
                    fail_next   = 1'b0;
                    if (s_tdata[0])
                    begin
                        count_next = '0;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                else if (!v1_reg && !v2_reg && !v3_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold here until the output register is free.
                if (!out_valid_reg || m_tready)
                begin
                    mem_we         = !fail_reg && room;
                    count_next     = mem_we ? count_reg + 1'b1 : count_reg;
                    size_wide      = {{SIZE_W{1'b0}}, count_next};
                    accepted_next  = mem_we;
                    full_next      = !fail_reg && !room;
                    size_next      = size_wide[SIZE_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            fail_reg      <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            accepted_reg  <= 1'b0;
            full_reg      <= 1'b0;
            size_reg      <= '0;
            thresh_reg    <= THRESH_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            fail_reg      <= fail_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            out_valid_reg <= out_valid_next;
            accepted_reg  <= accepted_next;
            full_reg      <= full_next;
            size_reg      <= size_next;
            thresh_reg    <= thresh_next;
        end
    end

    // Point memory. Writes happen only at the end of an item and reads only
    // during the next scan, so the two ports never touch the same row at once.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[AW-1:0]] <= cand_reg;
        end
        if (issue)
        begin
            rdata_reg <= mem[rd_idx_reg[AW-1:0]];
        end
    end

    // Partial sums over the lower and upper halves of the squared differences.
    always_comb
    begin
        lo_sum = '0;
        hi_sum = '0;
        for (int d = 0; d < DIMENSIONS; d++)
        begin
            if (d < HALF)
            begin
                lo_sum = lo_sum + SUM_W'(sq_reg[d]);
            end
            else
            begin
                hi_sum = hi_sum + SUM_W'(sq_reg[d]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cand_reg <= cand_in;
        end
        for (int d = 0; d < DIMENSIONS; d++)
        begin
            logic [COORD_W-1:0] a;
            logic [COORD_W-1:0] b;
            logic [COORD_W-1:0] diff;
            a    = rdata_reg[d*COORD_W +: COORD_W];
            b    = cand_reg[d*COORD_W +: COORD_W];
            diff = (a >= b) ? (a - b) : (b - a);
            sq_reg[d] <= SQ_W'(diff) * SQ_W'(diff);
        end
        lo_reg <= lo_sum;
        hi_reg <= hi_sum;
    end

    // The stored count never goes past the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond capacity");

    // A point is written only while there is room for it.
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> room && !fail_reg)
        else $error("point written without room or after a failed check");

    // The scan never reads past the stored points.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_idx_reg <= count_reg)
        else $error("scan index beyond stored points");

    // Nothing is left in the distance pipeline when a new point is taken.
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !v1_reg && !v2_reg && !v3_reg)
        else $error("distance pipeline busy while idle");

    // A result is never both appended and rejected for a full store.
    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(accepted_reg && full_reg))
        else $error("accepted and store_full both set");

endmodule
